### design/sprite_planar_pixel_fetch_core_defines.svh
// assertion macros for the sprite pixel fetch checker
`ifndef SPRITE_PLANAR_PIXEL_FETCH_CORE_DEFINES_SVH
`define SPRITE_PLANAR_PIXEL_FETCH_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SPFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("spfp check failed");

// consequent must hold in the cycle after the antecedent
`define SPFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("spfp check failed");

`endif

### design/spfp_pkg.sv
// shared types, constants and helper functions of the sprite pixel fetch core
package spfp_pkg;

    localparam int VIDEO_WORDS    = 32768;
    localparam int VA_W           = $clog2(VIDEO_WORDS);
    localparam int COLOUR_ENTRIES = 256;
    localparam int CA_W           = $clog2(COLOUR_ENTRIES);
    localparam int ADDR_W         = 15;
    localparam int DATA_W         = 16;
    localparam int BGR_W          = 15;
    localparam int CFG_IDX_W      = 2;

    localparam logic [ADDR_W-1:0] TILE_BASE_FIRST_RST  = 15'h0000;
    localparam logic [ADDR_W-1:0] TILE_BASE_SECOND_RST = 15'h1000;
    localparam logic [ADDR_W-1:0] PLANE_OFFSET         = 15'd8;
    localparam logic [7:0]        RGBA_ALPHA           = 8'hff;

    typedef logic [1:0] func_t;
    localparam func_t FUNC_WRITE_VIDEO  = 2'd0;
    localparam func_t FUNC_WRITE_COLOUR = 2'd1;
    localparam func_t FUNC_FETCH        = 2'd2;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_TILE_BASE_FIRST  = 2'd0;
    localparam cfg_index_t REG_TILE_BASE_SECOND = 2'd1;

    typedef struct packed {
        logic [1:0]        func;
        logic [ADDR_W-1:0] mem_address;
        logic [DATA_W-1:0] write_data;
        logic [15:0]       attr;
        logic [6:0]        obj_size;
        logic [5:0]        pixel_x;
        logic [5:0]        pixel_y;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  color_index;
        logic        opaque;
        logic [31:0] rgba_color;
    } out_item_t;

    // stage one register contents
    typedef struct packed {
        logic              valid;
        func_t             func;
        logic [ADDR_W-1:0] tile_addr;
        logic [ADDR_W-1:0] mem_address;
        logic [DATA_W-1:0] write_data;
        logic [2:0]        palette;
        logic [2:0]        shift;
    } s1_t;

    function automatic logic [7:0] widen5(input logic [4:0] n);
        return {n, n[4:2]};
    endfunction

    function automatic logic [31:0] to_rgba(input logic [BGR_W-1:0] bgr);
        return {RGBA_ALPHA, widen5(bgr[4:0]), widen5(bgr[9:5]), widen5(bgr[14:10])};
    endfunction

endpackage

### design/spfp_ram.sv
// generic single write port ram with registered read
module spfp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/spfp_addr_stage.sv
// stage one: flips, tile number and plane word address
module spfp_addr_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  spfp_pkg::in_item_t          in_item,
    input  logic [spfp_pkg::ADDR_W-1:0] tile_base_first,
    input  logic [spfp_pkg::ADDR_W-1:0] tile_base_second,
    output spfp_pkg::s1_t               s1
);

    logic [5:0]                  xf;
    logic [5:0]                  yf;
    logic [4:0]                  tile_row;
    logic [3:0]                  tile_col;
    logic [spfp_pkg::ADDR_W-1:0] base;
    logic [spfp_pkg::ADDR_W-1:0] addr_next;
    logic                        valid_reg;
    spfp_pkg::s1_t               data_reg;

    always_comb begin
        xf = in_item.attr[14] ? (in_item.obj_size[5:0] - 6'd1 - in_item.pixel_x)
                              : in_item.pixel_x;
        yf = in_item.attr[15] ? (in_item.obj_size[5:0] - 6'd1 - in_item.pixel_y)
                              : in_item.pixel_y;
        // row may carry past the nibble, column wraps at 16
        tile_row  = {1'b0, in_item.attr[7:4]} + {2'b00, yf[5:3]};
        tile_col  = in_item.attr[3:0] + {1'b0, xf[5:3]};
        base      = in_item.attr[8] ? tile_base_second : tile_base_first;
        addr_next = base + {2'b00, tile_row, tile_col, 4'b0000} + {12'd0, yf[2:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg.valid       <= 1'b0;
            data_reg.func        <= in_item.func;
            data_reg.tile_addr   <= addr_next;
            data_reg.mem_address <= in_item.mem_address;
            data_reg.write_data  <= in_item.write_data;
            data_reg.palette     <= in_item.attr[11:9];
            data_reg.shift       <= ~xf[2:0];
        end
    end

    always_comb begin
        s1       = data_reg;
        s1.valid = valid_reg;
    end

endmodule

### design/spfp_out_stage.sv
// output stage: colour expansion and result register
module spfp_out_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load_valid,
    input  logic [3:0]                 color_index,
    input  logic [spfp_pkg::BGR_W-1:0] bgr,
    output logic                       en,
    output logic                       m_valid,
    input  logic                       m_ready,
    output spfp_pkg::out_item_t        m_item
);

    logic                m_valid_reg;
    spfp_pkg::out_item_t item_reg;
    spfp_pkg::out_item_t item_next;

    assign en = !m_valid_reg || m_ready;

    always_comb begin
        item_next.color_index = color_index;
        item_next.opaque      = (color_index != 4'd0);
        item_next.rgba_color  = item_next.opaque ? spfp_pkg::to_rgba(bgr) : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= load_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = item_reg;

endmodule

### design/sprite_planar_pixel_fetch_core.sv
// sprite planar pixel fetch core: four stage pipeline over video and colour memories
// a fetch result reaches m_item through the stage one, plane read, colour lookup and output registers in turn
// throughput: one transaction per cycle; the video ram is held twice so both plane
// words are read in the same cycle, and each stage stalls only when the one after is full
// reset clears the pipeline valid bits and sets the tile bases to 0 and 4096;
// the memories are not cleared and hold nothing defined until written
module sprite_planar_pixel_fetch_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  spfp_pkg::in_item_t          s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output spfp_pkg::out_item_t         m_item,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  spfp_pkg::cfg_index_t        cfg_index,
    input  logic [spfp_pkg::ADDR_W-1:0] cfg_data
);

    logic [spfp_pkg::ADDR_W-1:0] tile_base_first_reg;
    logic [spfp_pkg::ADDR_W-1:0] tile_base_second_reg;

    spfp_pkg::s1_t               s1;
    logic                        en1, en2, en3, en4;
    logic [spfp_pkg::ADDR_W-1:0] addr_hi;
    logic                        vwe;
    logic [spfp_pkg::DATA_W-1:0] plane_lo, plane_hi;

    logic                        v2_reg;
    spfp_pkg::func_t             func2_reg;
    logic [2:0]                  pal2_reg;
    logic [2:0]                  sh2_reg;
    logic [spfp_pkg::CA_W-1:0]   caddr_w2_reg;
    logic [spfp_pkg::BGR_W-1:0]  cdata2_reg;
    logic [3:0]                  idx_next;
    logic [spfp_pkg::CA_W-1:0]   caddr_r;
    logic                        cwe;
    logic [spfp_pkg::BGR_W-1:0]  bgr;

    logic                        v3_reg;
    spfp_pkg::func_t             func3_reg;
    logic [3:0]                  idx3_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_base_first_reg  <= spfp_pkg::TILE_BASE_FIRST_RST;
            tile_base_second_reg <= spfp_pkg::TILE_BASE_SECOND_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                spfp_pkg::REG_TILE_BASE_FIRST:  tile_base_first_reg  <= cfg_data;
                spfp_pkg::REG_TILE_BASE_SECOND: tile_base_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stall chain runs back from the output register
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !s1.valid || en2;
    assign s_ready = en1;

    spfp_addr_stage u_addr_stage (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (en1),
        .in_valid         (s_valid),
        .in_item          (s_item),
        .tile_base_first  (tile_base_first_reg),
        .tile_base_second (tile_base_second_reg),
        .s1               (s1)
    );

    // stage two: plane word reads, video writes in the same stage keep order
    assign addr_hi = s1.tile_addr + spfp_pkg::PLANE_OFFSET;
    assign vwe     = en2 && s1.valid && (s1.func == spfp_pkg::FUNC_WRITE_VIDEO);

    spfp_ram #(.WIDTH(spfp_pkg::DATA_W), .DEPTH(spfp_pkg::VIDEO_WORDS)) u_video_lo (
        .aclk  (aclk),
        .we    (vwe),
        .waddr (s1.mem_address[spfp_pkg::VA_W-1:0]),
        .wdata (s1.write_data),
        .re    (en2),
        .raddr (s1.tile_addr[spfp_pkg::VA_W-1:0]),
        .rdata (plane_lo)
    );

    spfp_ram #(.WIDTH(spfp_pkg::DATA_W), .DEPTH(spfp_pkg::VIDEO_WORDS)) u_video_hi (
        .aclk  (aclk),
        .we    (vwe),
        .waddr (s1.mem_address[spfp_pkg::VA_W-1:0]),
        .wdata (s1.write_data),
        .re    (en2),
        .raddr (addr_hi[spfp_pkg::VA_W-1:0]),
        .rdata (plane_hi)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= s1.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            func2_reg    <= s1.func;
            pal2_reg     <= s1.palette;
            sh2_reg      <= s1.shift;
            caddr_w2_reg <= s1.mem_address[spfp_pkg::CA_W-1:0];
            cdata2_reg   <= s1.write_data[spfp_pkg::BGR_W-1:0];
        end
    end

    // stage three: bit plane decode and colour lookup
    assign idx_next = {plane_hi[{1'b1, sh2_reg}], plane_hi[{1'b0, sh2_reg}],
                       plane_lo[{1'b1, sh2_reg}], plane_lo[{1'b0, sh2_reg}]};
    // sprite palettes sit in the upper half of colour memory
    assign caddr_r  = {1'b1, pal2_reg, idx_next};
    assign cwe      = en3 && v2_reg && (func2_reg == spfp_pkg::FUNC_WRITE_COLOUR);

    spfp_ram #(.WIDTH(spfp_pkg::BGR_W), .DEPTH(spfp_pkg::COLOUR_ENTRIES)) u_colour (
        .aclk  (aclk),
        .we    (cwe),
        .waddr (caddr_w2_reg),
        .wdata (cdata2_reg),
        .re    (en3),
        .raddr (caddr_r),
        .rdata (bgr)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            func3_reg <= func2_reg;
            idx3_reg  <= idx_next;
        end
    end

    // stage four: only fetches produce a result
    spfp_out_stage u_out_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load_valid  (v3_reg && (func3_reg == spfp_pkg::FUNC_FETCH)),
        .color_index (idx3_reg),
        .bgr         (bgr),
        .en          (en4),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

endmodule

### design/spfp_checker.sv
// port level checks for the sprite pixel fetch core, bound to the top level
`include "sprite_planar_pixel_fetch_core_defines.svh"

module spfp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input spfp_pkg::out_item_t m_item,
    input logic                cfg_valid,
    input logic                cfg_ready
);

    `SPFP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_item))
    `SPFP_ASSERT_SAME(a_opaque_flag, aclk, aresetn, m_valid, m_item.opaque == (m_item.color_index != 4'd0))
    `SPFP_ASSERT_SAME(a_transparent_black, aclk, aresetn, m_valid && !m_item.opaque, m_item.rgba_color == 32'd0)
    `SPFP_ASSERT_SAME(a_opaque_alpha, aclk, aresetn, m_valid && m_item.opaque, m_item.rgba_color[31:24] == spfp_pkg::RGBA_ALPHA)
    `SPFP_ASSERT_SAME(a_cfg_always_ready, aclk, aresetn, cfg_valid, cfg_ready)

endmodule

bind sprite_planar_pixel_fetch_core spfp_checker u_spfp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_item    (m_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
